// File: rtl/core/ssd_pkg.sv
// Shared types, constants and the symbol lookup for the seed string decoder.
package ssd_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned SymW   = 5;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned NumChr = 9;

  localparam logic [CharW-1:0] SEED_LEN  = 8'd9;
  localparam logic [CharW-1:0] SEP_CHAR  = 8'h20;
  localparam logic [SeedW-1:0] SEED_MASK = 32'h0FEF_7FFD;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_LENGTH   = 3'd1,
    ST_NO_SEPARATOR = 3'd2,
    ST_BAD_CHAR     = 3'd3,
    ST_CHECK        = 3'd4
  } decode_status_t;

  // One looked-up character: valid flag and 5-bit symbol value.
  typedef struct packed {
    logic            valid;
    logic [SymW-1:0] val;
  } sym_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic decode;
    logic step;
    logic finish;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic early_fail;
    logic r_zero;
    logic out_busy;
  } dp_stat_t;

  // Maps a character byte onto the case-sensitive 32-symbol alphabet.
  function automatic sym_t sym_lookup(input logic [CharW-1:0] c);
    sym_t s;
    s.valid = 1'b1;
    s.val   = '0;
    unique case (c)
      "A": s.val = 5'd0;
      "B": s.val = 5'd1;
      "C": s.val = 5'd2;
      "D": s.val = 5'd3;
      "E": s.val = 5'd4;
      "F": s.val = 5'd5;
      "G": s.val = 5'd6;
      "H": s.val = 5'd7;
      "J": s.val = 5'd8;
      "K": s.val = 5'd9;
      "L": s.val = 5'd10;
      "M": s.val = 5'd11;
      "N": s.val = 5'd12;
      "P": s.val = 5'd13;
      "Q": s.val = 5'd14;
      "R": s.val = 5'd15;
      "S": s.val = 5'd16;
      "T": s.val = 5'd17;
      "W": s.val = 5'd18;
      "X": s.val = 5'd19;
      "Y": s.val = 5'd20;
      "Z": s.val = 5'd21;
      "0": s.val = 5'd22;
      "1": s.val = 5'd23;
      "2": s.val = 5'd24;
      "3": s.val = 5'd25;
      "4": s.val = 5'd26;
      "V": s.val = 5'd27;
      "6": s.val = 5'd28;
      "7": s.val = 5'd29;
      "8": s.val = 5'd30;
      "9": s.val = 5'd31;
      default: s.valid = 1'b0;
    endcase
    return s;
  endfunction

endpackage

// File: rtl/core/seed_string_decoder_core.sv
// Top level of the seed string decoder: controller plus datapath.
//
// Usage: one input transaction on the s_ group carries a seed string
// (length byte and nine character bytes); one result transaction on the
// m_ group carries the 32-bit seed and a 3-bit status for it.
// Status: 0 ok, 1 bad length, 2 no separator, 3 invalid character,
// 4 check mismatch; the seed is zero whenever the status is not ok.
// Sequence: after the accepting edge come a decode state, up to seven
// check rounds (one per cycle, until the remainder of the 32-bit seed
// shifted by 5 reaches zero; none when the string was rejected early),
// a check state that sees the remainder exhausted or the early failure,
// and a finish state that loads the output register and raises m_tvalid.
// Flow: one transaction at a time; s_tready is high only while the
// controller is idle, so a string is taken only once the last one is done.
// Reset (rst, synchronous, active high) returns the controller to idle and
// empties the output register.
// When the receiver stalls, the result is held in the output register and
// the next string is still accepted and worked on; it then waits before
// its own output cycle until the held result has been taken.
module seed_string_decoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [7:0] text_length, [15:8] char_0, [23:16] char_1, ..., [79:72] char_8
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] seed_value, [34:32] decode_status, [39:35] zero
  output logic [39:0] m_tdata
);
  import ssd_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [31:0] seed_value;
  logic [2:0]  decode_status;

  ssd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  ssd_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_seed   (seed_value),
    .out_status (decode_status)
  );

  assign m_tdata = {5'b0, decode_status, seed_value};

endmodule

// File: rtl/core/ssd_dp.sv
// Datapath of the seed string decoder: input capture, symbol decode, check rounds, output.
module ssd_dp (
  input  logic                clk,
  input  logic                rst,
  input  ssd_pkg::dp_cmd_t    cmd,
  output ssd_pkg::dp_stat_t   stat,
  input  logic [79:0]         in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [31:0]         out_seed,
  output logic [2:0]          out_status
);
  import ssd_pkg::*;

  logic [CharW-1:0] len;
  logic [CharW-1:0] chr [NumChr];

  logic [SeedW-1:0] seed;
  logic [CharW-1:0] expect_chk;
  decode_status_t   early_status;
  logic             early_fail;
  logic [SeedW-1:0] r;
  logic [CharW-1:0] d;

  sym_t             sym [8];
  logic [SymW-1:0]  v   [8];
  logic [SeedW-1:0] seed_comb;
  decode_status_t   status_comb;
  logic [CharW-1:0] d_sum;
  logic [CharW-1:0] d_rot;

  // Look up the eight non-separator characters in parallel.
  always_comb begin
    for (int i = 0; i < 8; i++) begin
      sym[i] = sym_lookup((i < 4) ? chr[i] : chr[i+1]);
      v[i]   = sym[i].val;
    end
  end

  // Pack the first 32 symbol bits, XOR them with SEED_MASK, and pick the first failure in order.
  always_comb begin
    seed_comb = {v[0], v[1], v[2], v[3], v[4], v[5], v[6][4:3]} ^ SEED_MASK;
    status_comb = ST_OK;
    if (len != SEED_LEN) begin
      status_comb = ST_BAD_LENGTH;
    end else if (chr[4] != SEP_CHAR) begin
      status_comb = ST_NO_SEPARATOR;
    end else begin
      for (int i = 0; i < 8; i++) begin
        if (!sym[i].valid) begin
          status_comb = ST_BAD_CHAR;
        end
      end
    end
  end

  // One check round: add the low byte of the remainder, then rotate left.
  assign d_sum = r[CharW-1:0] + d;
  assign d_rot = {d_sum[CharW-2:0], d_sum[CharW-1]};

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      len <= in_data[7:0];
      for (int i = 0; i < NumChr; i++) begin
        chr[i] <= in_data[8*(i+1) +: 8];
      end
    end
    if (cmd.decode) begin
      seed         <= seed_comb;
      expect_chk   <= {v[6][2:0], v[7]};
      early_status <= status_comb;
      early_fail   <= (status_comb != ST_OK);
      r            <= seed_comb;
      d            <= '0;
    end else if (cmd.step) begin
      r <= r >> SymW;
      d <= d_rot;
    end
    if (cmd.finish) begin
      if (early_fail) begin
        out_status <= early_status;
        out_seed   <= '0;
      end else if (d != expect_chk) begin
        out_status <= ST_CHECK;
        out_seed   <= '0;
      end else begin
        out_status <= ST_OK;
        out_seed   <= seed;
      end
    end
  end

  // Output register occupancy.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.early_fail = early_fail;
  assign stat.r_zero     = (r == '0);
  assign stat.out_busy   = out_valid & ~out_ready;

endmodule

// File: rtl/core/ssd_ctrl.sv
// Controller state machine of the seed string decoder.
module ssd_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output ssd_pkg::dp_cmd_t  cmd,
  input  ssd_pkg::dp_stat_t stat
);
  import ssd_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_CHECK,
    S_FINISH
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // Commands follow from the state and the datapath status.
  always_comb begin
    cmd        = '0;
    cmd.load   = (state == S_IDLE) && in_valid;
    cmd.decode = (state == S_DECODE);
    cmd.step   = (state == S_CHECK) && !stat.early_fail && !stat.r_zero;
    cmd.finish = (state == S_FINISH) && !stat.out_busy;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_DECODE;
          end
        end
        S_DECODE: begin
          state <= S_CHECK;
        end
        S_CHECK: begin
          if (stat.early_fail || stat.r_zero) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!stat.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  // An accepted transaction is decoded in the very next cycle.
  a_load_decode: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> cmd.decode)
    else $error("decode did not follow load");

  // The output register is never overwritten while its result waits.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !stat.out_busy)
    else $error("finish while output busy");

  // A check round never runs on an exhausted remainder.
  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> !stat.r_zero)
    else $error("check step with zero remainder");

  // No new transaction is taken while one is in progress.
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (cmd.decode || cmd.step || cmd.finish) |-> !in_ready)
    else $error("input ready during processing");
`endif

endmodule
